// File: hdl/weighted_range_char_picker_assert.svh
// assertion macros for the weighted range character picker checker
`ifndef WEIGHTED_RANGE_CHAR_PICKER_ASSERT_SVH
`define WEIGHTED_RANGE_CHAR_PICKER_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define WRCP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define WRCP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/wrcp_pkg.sv
// shared constants, types and the utf-8 encoder of the weighted range character picker
package wrcp_pkg;

    // table geometry
    localparam int MAX_RANGES = 16;
    localparam int LOG_R      = $clog2(MAX_RANGES);
    localparam int IDX_W      = (LOG_R == 0) ? 1 : LOG_R;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    // field widths
    localparam int CP_W      = 21;
    localparam int SIZE_W    = 22;
    localparam int ENTRY_W   = CP_W + SIZE_W;
    localparam int TOT_W     = SIZE_W + LOG_R;
    localparam int WORD_W    = 64;
    localparam int HALF_W    = WORD_W / 2;
    localparam int EIDX_W    = 4;
    localparam int RIU_W     = 5;
    localparam int S_TDATA_W = ((EIDX_W + 2 * CP_W + WORD_W + 7) / 8) * 8;

    // remainder unit step counts
    localparam int STEP_W = $clog2(WORD_W + 1);
    localparam logic [STEP_W-1:0] MOD_FULL_STEPS = STEP_W'(WORD_W);
    localparam logic [STEP_W-1:0] MOD_HALF_STEPS = STEP_W'(HALF_W);

    // apb
    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_RANGES_IN_USE = 1'b0;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_GEN  = 1'b1;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_INVERTED = 2'd2;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [WORD_W-1:0] dividend;
        logic [TOT_W-1:0]  divisor;
    } wrcp_mod_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [TOT_W-1:0] rem;
    } wrcp_mod_rsp_t;

    typedef struct packed {
        logic [3:0][7:0] octets;
        logic [1:0]      last_idx;
    } wrcp_utf8_t;

    // plain utf-8 bit pattern, surrogates included
    function automatic wrcp_utf8_t utf8_encode(input logic [CP_W-1:0] cp);
        wrcp_utf8_t r;
        r = '0;
        if (cp < CP_W'(32'h80)) begin
            r.octets[0] = {1'b0, cp[6:0]};
            r.last_idx  = 2'd0;
        end else if (cp < CP_W'(32'h800)) begin
            r.octets[0] = {3'b110, cp[10:6]};
            r.octets[1] = {2'b10, cp[5:0]};
            r.last_idx  = 2'd1;
        end else if (cp < CP_W'(32'h10000)) begin
            r.octets[0] = {4'b1110, cp[15:12]};
            r.octets[1] = {2'b10, cp[11:6]};
            r.octets[2] = {2'b10, cp[5:0]};
            r.last_idx  = 2'd2;
        end else begin
            r.octets[0] = {5'b11110, cp[20:18]};
            r.octets[1] = {2'b10, cp[17:12]};
            r.octets[2] = {2'b10, cp[11:6]};
            r.octets[3] = {2'b10, cp[5:0]};
            r.last_idx  = 2'd3;
        end
        return r;
    endfunction

endpackage

// File: hdl/wrcp_table_ram.sv
// range table memory: one write port, one read port, registered read data
module wrcp_table_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 43
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/wrcp_mod_unit.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
module wrcp_mod_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wrcp_pkg::wrcp_mod_req_t req,
    output wrcp_pkg::wrcp_mod_rsp_t rsp
);
    import wrcp_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [TOT_W-1:0]  dsr_reg, dsr_next;
    logic [TOT_W-1:0]  rem_reg, rem_next;
    logic [TOT_W:0]    trial;

    always_comb begin
        trial     = {rem_reg, dvd_reg[WORD_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg - STEP_W'(1);
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = TOT_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[TOT_W-1:0];
            end
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// File: hdl/weighted_range_char_picker.sv
// weighted range character picker: top level with sequencer, table and remainder unit
//
// Holds a table of up to MAX_RANGES code-point ranges in a single-port-read memory. A load
// transaction (s_tuser = 0) writes one entry as start and size; an inverted range is
// refused with status 2 and leaves the table unchanged, an index past the table is
// acknowledged with status 0 and writes nothing. A generate transaction (s_tuser = 1)
// sums the sizes of the first ranges_in_use entries, capped at MAX_RANGES, reduces the
// 64-bit random word modulo that total, walks the cumulative sizes to choose an entry,
// adds the low 32 bits of the word modulo the entry size to its start, and sends the code
// point as one to four UTF-8 bytes, tlast on the final byte, status in m_tuser. No ranges
// in use gives one byte of 0 with status 1. One transaction is handled at a time. A load
// offers its result in the cycle after acceptance. A generate makes two passes over the
// table at one entry read per cycle and runs two bit-serial remainders in the shared
// unit, 64 steps for the word and 32 for the offset. Table entries read as undefined
// until loaded, so there is no clearing pass.
module weighted_range_char_picker (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata from bit 0: entry_index[3:0], range_first[20:0], range_last[20:0],
    // random_word[63:0], zero fill
    input  logic [wrcp_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: opcode
    input  logic [0:0]                      s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: out_byte
    output logic [7:0]                      m_tdata,
    output logic                            m_tlast,
    // m_tuser: status
    output logic [1:0]                      m_tuser,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wrcp_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import wrcp_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SUM  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_MOD1 = 4'd3;
    localparam logic [3:0] S_WALK = 4'd4;
    localparam logic [3:0] S_CHK2 = 4'd5;
    localparam logic [3:0] S_MOD2 = 4'd6;
    localparam logic [3:0] S_EMIT = 4'd7;

    // unpacked input fields
    logic              in_opcode;
    logic [EIDX_W-1:0] in_index;
    logic [CP_W-1:0]   in_first;
    logic [CP_W-1:0]   in_last;
    logic [WORD_W-1:0] in_word;

    assign in_opcode = s_tuser[0];
    assign in_index  = s_tdata[EIDX_W-1:0];
    assign in_first  = s_tdata[EIDX_W+CP_W-1:EIDX_W];
    assign in_last   = s_tdata[EIDX_W+2*CP_W-1:EIDX_W+CP_W];
    assign in_word   = s_tdata[EIDX_W+2*CP_W+WORD_W-1:EIDX_W+2*CP_W];

    // configuration register
    logic [RIU_W-1:0] riu_reg;
    logic             cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[ADDR_W-1:2] == REG_RANGES_IN_USE);
    assign prdata = (paddr[ADDR_W-1:2] == REG_RANGES_IN_USE) ? 32'(riu_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            riu_reg <= '0;
        end else if (cfg_we) begin
            riu_reg <= pwdata[RIU_W-1:0];
        end
    end

    // sequencer registers
    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  issue_ptr_reg, issue_ptr_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  data_idx_reg, data_idx_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [TOT_W-1:0]  cum_reg, cum_next;
    logic              found_reg, found_next;
    logic [CP_W-1:0]   chosen_start_reg, chosen_start_next;
    logic [SIZE_W-1:0] chosen_size_reg, chosen_size_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [3:0][7:0]   byte_buf_reg, byte_buf_next;
    logic [1:0]        last_idx_reg, last_idx_next;
    logic [1:0]        byte_ptr_reg, byte_ptr_next;
    logic [1:0]        status_reg, status_next;

    // table memory
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [CP_W-1:0]    rd_start;
    logic [SIZE_W-1:0]  rd_size;

    // remainder unit
    wrcp_mod_req_t mod_req;
    wrcp_mod_rsp_t mod_rsp;

    // helpers
    logic              s_acc;
    logic              inverted;
    logic              in_table;
    logic [CNT_W-1:0]  n_eff;
    logic              issue;
    logic              last_data;
    logic [TOT_W-1:0]  acc_sum;
    logic [SIZE_W-1:0] in_size;
    logic [SIZE_W-1:0] cp_sum;
    wrcp_utf8_t        enc;

    assign s_acc    = s_tvalid && s_tready;
    assign inverted = in_last < in_first;
    assign in_table = 32'(in_index) < MAX_RANGES;
    assign n_eff    = (32'(riu_reg) > MAX_RANGES) ? CNT_W'(MAX_RANGES) : CNT_W'(riu_reg);
    assign in_size  = SIZE_W'({1'b0, in_last} - {1'b0, in_first} + SIZE_W'(1));

    assign rd_start = ram_rdata[ENTRY_W-1:SIZE_W];
    assign rd_size  = ram_rdata[SIZE_W-1:0];

    // table passes issue one read per cycle, data comes back in the following cycle
    assign issue     = ((state_reg == S_SUM) || (state_reg == S_WALK)) && (issue_ptr_reg < n_reg);
    assign last_data = rd_vld_reg && (CNT_W'(data_idx_reg) == CNT_W'(n_reg - CNT_W'(1)));
    assign acc_sum   = ((state_reg == S_SUM) ? total_reg : cum_reg) + TOT_W'(rd_size);

    // code point: start plus the offset remainder, kept to 21 bits
    assign cp_sum = SIZE_W'(chosen_start_reg) + mod_rsp.rem[SIZE_W-1:0];
    assign enc    = utf8_encode(cp_sum[CP_W-1:0]);

    // load writes the table at acceptance
    assign ram_we    = s_acc && (in_opcode == OP_LOAD) && !inverted && in_table;
    assign ram_waddr = IDX_W'(in_index);
    assign ram_wdata = {in_first, in_size};
    assign ram_re    = issue;

    wrcp_table_ram #(
        .DEPTH  (MAX_RANGES),
        .ADDR_W (IDX_W),
        .DATA_W (ENTRY_W)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_ptr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    wrcp_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    always_comb begin
        state_next        = state_reg;
        n_next            = n_reg;
        issue_ptr_next    = issue_ptr_reg;
        rd_vld_next       = issue;
        data_idx_next     = issue_ptr_reg[IDX_W-1:0];
        total_next        = total_reg;
        cum_next          = cum_reg;
        found_next        = found_reg;
        chosen_start_next = chosen_start_reg;
        chosen_size_next  = chosen_size_reg;
        word_next         = word_reg;
        byte_buf_next     = byte_buf_reg;
        last_idx_next     = last_idx_reg;
        byte_ptr_next     = byte_ptr_reg;
        status_next       = status_reg;
        mod_req           = '0;
        s_tready          = 1'b0;

        if (issue) begin
            issue_ptr_next = issue_ptr_reg + CNT_W'(1);
        end

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_acc) begin
                    byte_buf_next = '0;
                    last_idx_next = 2'd0;
                    byte_ptr_next = 2'd0;
                    if (in_opcode == OP_LOAD) begin
                        status_next = inverted ? STAT_INVERTED : STAT_OK;
                        state_next  = S_EMIT;
                    end else begin
                        n_next         = n_eff;
                        word_next      = in_word;
                        issue_ptr_next = '0;
                        total_next     = '0;
                        if (n_eff == '0) begin
                            status_next = STAT_EMPTY;
                            state_next  = S_EMIT;
                        end else begin
                            state_next = S_SUM;
                        end
                    end
                end
            end
            // first pass: total of the sizes in use
            S_SUM: begin
                if (rd_vld_reg) begin
                    total_next = acc_sum;
                end
                if (last_data) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (total_reg == '0) begin
                    status_next = STAT_EMPTY;
                    state_next  = S_EMIT;
                end else begin
                    mod_req.start    = 1'b1;
                    mod_req.steps    = MOD_FULL_STEPS;
                    mod_req.dividend = word_reg;
                    mod_req.divisor  = total_reg;
                    issue_ptr_next   = '0;
                    cum_next         = '0;
                    found_next       = 1'b0;
                    state_next       = S_MOD1;
                end
            end
            S_MOD1: begin
                if (mod_rsp.done) begin
                    issue_ptr_next = '0;
                    state_next     = S_WALK;
                end
            end
            // second pass: first entry whose running sum passes the pick,
            // the pick stays in the remainder unit until its next start
            S_WALK: begin
                if (rd_vld_reg) begin
                    cum_next = acc_sum;
                    if (!found_reg && (mod_rsp.rem < acc_sum)) begin
                        found_next        = 1'b1;
                        chosen_start_next = rd_start;
                        chosen_size_next  = rd_size;
                    end
                end
                if (last_data) begin
                    state_next = S_CHK2;
                end
            end
            S_CHK2: begin
                if (!found_reg || (chosen_size_reg == '0)) begin
                    status_next = STAT_EMPTY;
                    state_next  = S_EMIT;
                end else begin
                    // low half of the word, moved up so the unit runs 32 steps
                    mod_req.start    = 1'b1;
                    mod_req.steps    = MOD_HALF_STEPS;
                    mod_req.dividend = {word_reg[HALF_W-1:0], {HALF_W{1'b0}}};
                    mod_req.divisor  = TOT_W'(chosen_size_reg);
                    state_next       = S_MOD2;
                end
            end
            S_MOD2: begin
                if (mod_rsp.done) begin
                    byte_buf_next = enc.octets;
                    last_idx_next = enc.last_idx;
                    byte_ptr_next = 2'd0;
                    status_next   = STAT_OK;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (m_tready) begin
                    if (byte_ptr_reg == last_idx_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        byte_ptr_next = byte_ptr_reg + 2'd1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            issue_ptr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            byte_ptr_reg  <= 2'd0;
        end else begin
            state_reg     <= state_next;
            issue_ptr_reg <= issue_ptr_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            byte_ptr_reg  <= byte_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg            <= n_next;
        data_idx_reg     <= data_idx_next;
        total_reg        <= total_next;
        cum_reg          <= cum_next;
        chosen_start_reg <= chosen_start_next;
        chosen_size_reg  <= chosen_size_next;
        word_reg         <= word_next;
        byte_buf_reg     <= byte_buf_next;
        last_idx_reg     <= last_idx_next;
        status_reg       <= status_next;
    end

    // result channel straight from registers
    assign m_tvalid = (state_reg == S_EMIT);
    assign m_tdata  = byte_buf_reg[byte_ptr_reg];
    assign m_tlast  = (byte_ptr_reg == last_idx_reg);
    assign m_tuser  = status_reg;

endmodule

// File: hdl/wrcp_checker.sv
// port-level checker for the weighted range character picker, bound to the top level
`include "weighted_range_char_picker_assert.svh"

module wrcp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);
    import wrcp_pkg::*;

    // result offered with a non-ok status
    logic err_beat;

    assign err_beat = m_tvalid && (m_tuser != STAT_OK);

    // a stalled result stays offered
    `WRCP_ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // one transaction in flight: no input taken while a result is offered
    `WRCP_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready, "input ready while result pending")

    // after an input is taken the block is not ready again in the next cycle
    `WRCP_ASSERT_NXT(a_busy_after_acc, s_tvalid && s_tready, !s_tready, "ready right after accept")

    // a non-ok status is always a single zero byte
    `WRCP_ASSERT_IMP(a_err_single, err_beat, m_tlast && (m_tdata == 8'd0), "bad error result")

endmodule

bind weighted_range_char_picker wrcp_checker u_wrcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: test/wrcp_char_checker.sv
// result checker for the weighted range character picker: mirrors the range table and compares bytes
module wrcp_char_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [wrcp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [7:0]                     m_tdata,
    input  logic                           m_tlast,
    input  logic [1:0]                     m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wrcp_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    output int                             error_count,
    output int                             expected_left
);
    timeunit 1ns;
    timeprecision 1ps;

    import wrcp_pkg::*;

    localparam int FIRST_LSB = EIDX_W;
    localparam int LAST_LSB  = EIDX_W + CP_W;
    localparam int WORD_LSB  = EIDX_W + 2 * CP_W;

    typedef struct packed {
        logic [7:0] octet;
        logic       final_octet;
        logic [1:0] status;
    } utf8_octet_t;

    logic [CP_W-1:0]   span_start [MAX_RANGES];
    logic [SIZE_W-1:0] span_size  [MAX_RANGES];
    logic [RIU_W-1:0]  ranges_in_use;
    utf8_octet_t       octets_due [$];
    int                mismatches = 0;
    int                due_count  = 0;

    assign error_count   = mismatches;
    assign expected_left = due_count;

    function automatic void push_octet(input logic [7:0] octet, input logic fin,
                                       input logic [1:0] status);
        utf8_octet_t e;
        e.octet       = octet;
        e.final_octet = fin;
        e.status      = status;
        octets_due.push_back(e);
    endfunction

    // expected bytes for one accepted transaction, table updates included
    function automatic void predict_char_octets(input logic op, input logic [EIDX_W-1:0] idx,
                                                input logic [CP_W-1:0] first,
                                                input logic [CP_W-1:0] lastcp,
                                                input logic [WORD_W-1:0] word);
        int unsigned       active;
        int                i;
        int                chosen;
        int                len;
        logic [63:0]       total;
        logic [63:0]       pick;
        logic [63:0]       cum;
        logic [31:0]       offset;
        logic [CP_W-1:0]   cp;
        logic [7:0]        seq [4];
        if (op == OP_LOAD) begin
            if (lastcp < first) begin
                push_octet(8'h00, 1'b1, STAT_INVERTED);
                return;
            end
            if (int'(idx) < MAX_RANGES) begin
                span_start[idx] = first;
                span_size[idx]  = SIZE_W'(lastcp) - SIZE_W'(first) + 1'b1;
            end
            push_octet(8'h00, 1'b1, STAT_OK);
            return;
        end
        active = (ranges_in_use > MAX_RANGES) ? MAX_RANGES : ranges_in_use;
        total  = '0;
        for (i = 0; i < active; i++)
            total += 64'(span_size[i]);
        if (total == 0) begin
            push_octet(8'h00, 1'b1, STAT_EMPTY);
            return;
        end
        // weighted pick: walk the running sum of sizes
        pick   = word % total;
        cum    = '0;
        chosen = 0;
        for (i = 0; i < active; i++) begin
            cum += 64'(span_size[i]);
            if (pick < cum) begin
                chosen = i;
                break;
            end
        end
        offset = word[31:0] % 32'(span_size[chosen]);
        cp     = CP_W'(32'(span_start[chosen]) + offset);
        if (cp < CP_W'('h80)) begin
            seq[0] = {1'b0, cp[6:0]};
            len    = 1;
        end else if (cp < CP_W'('h800)) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            len    = 2;
        end else if (cp < CP_W'('h10000)) begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            len    = 3;
        end else begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
            len    = 4;
        end
        for (i = 0; i < len; i++)
            push_octet(seq[i], i == len - 1, STAT_OK);
    endfunction

    always @(posedge aclk) begin
        utf8_octet_t want;
        int          k;
        if (!aresetn) begin
            octets_due.delete();
            ranges_in_use = '0;
            for (k = 0; k < MAX_RANGES; k++) begin
                span_start[k] = '0;
                span_size[k]  = '0;
            end
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr[ADDR_W-1:2] == REG_RANGES_IN_USE)
                ranges_in_use = pwdata[RIU_W-1:0];
            if (s_tvalid && s_tready)
                predict_char_octets(s_tuser[0], s_tdata[EIDX_W-1:0],
                                    s_tdata[FIRST_LSB +: CP_W], s_tdata[LAST_LSB +: CP_W],
                                    s_tdata[WORD_LSB +: WORD_W]);
            if (m_tvalid && m_tready) begin
                if (octets_due.size() == 0) begin
                    $error("unexpected result transaction: out_byte %02h last %0b status %0d",
                           m_tdata, m_tlast, m_tuser);
                    mismatches++;
                end else begin
                    want = octets_due.pop_front();
                    if (m_tdata !== want.octet) begin
                        $error("out_byte: expected %02h, actual %02h", want.octet, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.final_octet) begin
                        $error("last: expected %0b, actual %0b", want.final_octet, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        mismatches++;
                    end
                end
            end
        end
        due_count = octets_due.size();
    end

endmodule

// File: test/tb_weighted_range_char_picker.sv
// testbench top for the weighted range character picker: stimulus, idling phases and verdict
module tb_weighted_range_char_picker;
    timeunit 1ns;
    timeprecision 1ps;

    import wrcp_pkg::*;

    // the limit stays well above the slowest correct run (about 330 transactions plus
    // random gaps and stalls), leaving a wide margin
    localparam int CYCLE_LIMIT   = 600_000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int SEGMENTS      = 12;
    localparam int SEGMENT_ITEMS = 24;
    localparam int CP_TOP        = 'h1FFFFF;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input channel
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // s_tdata from bit 0: entry_index, range_first, range_last, random_word, zero fill
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // s_tuser: opcode
    logic [0:0]           s_tuser  = '0;

    // result channel
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    // m_tdata: out_byte
    logic [7:0] m_tdata;
    logic       m_tlast;
    // m_tuser: status
    logic [1:0] m_tuser;

    // configuration port
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    // idling knobs, percent of cycles
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;
    int error_count;
    int expected_left;

    always #5 aclk = ~aclk;

    weighted_range_char_picker DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // checker watches both channels and the config port, predicts and compares
    wrcp_char_checker char_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .expected_left (expected_left)
    );

    // receiver back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_weighted_range_char_picker: errors");
            $finish;
        end
    end

    // one input transaction; entered and left at a falling edge, tvalid stays high
    // on return so back-to-back transactions need no second assignment in one step
    task automatic send_item(input logic op, input logic [EIDX_W-1:0] idx,
                             input logic [CP_W-1:0] first, input logic [CP_W-1:0] lastcp,
                             input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({word, lastcp, first, idx});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic load_entry(input logic [EIDX_W-1:0] idx, input logic [CP_W-1:0] first,
                              input logic [CP_W-1:0] lastcp);
        send_item(OP_LOAD, idx, first, lastcp, {$urandom, $urandom});
    endtask

    // unused fields of a generate transaction carry random noise
    task automatic gen_char(input logic [WORD_W-1:0] word);
        send_item(OP_GEN, EIDX_W'($urandom), CP_W'($urandom), CP_W'($urandom), word);
    endtask

    // hold the sender until every expected byte has come back
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (expected_left != 0);
    endtask

    // register write, only once the block has gone quiet
    task automatic write_ranges_in_use(input logic [RIU_W-1:0] value);
        wait_all_results();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'({REG_RANGES_IN_USE, 2'b00});
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // well-formed range: start in one utf-8 length class, mostly narrow spans
    task automatic random_range(output logic [CP_W-1:0] first, output logic [CP_W-1:0] lastcp);
        int unsigned lo, hi, f, room, span;
        case ($urandom_range(4))
            0:       begin lo = 0;        hi = 'h7F;    end
            1:       begin lo = 'h80;     hi = 'h7FF;   end
            2:       begin lo = 'h800;    hi = 'hFFFF;  end
            3:       begin lo = 'h10000;  hi = CP_TOP;  end
            default: begin lo = 0;        hi = CP_TOP;  end
        endcase
        f    = $urandom_range(hi, lo);
        room = hi - f;
        case ($urandom_range(3))
            0:       span = room;
            1:       span = $urandom_range(room, 0);
            default: span = (room < 16) ? $urandom_range(room, 0) : $urandom_range(15, 0);
        endcase
        first  = CP_W'(f);
        lastcp = CP_W'(f + span);
    endtask

    // mostly full-width words, some short ones so the upper bits sit at zero
    function automatic logic [WORD_W-1:0] random_word();
        if ($urandom_range(4) == 0)
            return WORD_W'($urandom_range(32'h3FF_FFFF, 0));
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [CP_W-1:0]  first, lastcp;
        logic [RIU_W-1:0] active;
        int               seg, item, e, pick;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed part, no idling ----
        // empty selection before any entry exists
        write_ranges_in_use(RIU_W'(0));
        gen_char('1);
        // extremes of index and code point, inverted loads leave the table alone
        load_entry(EIDX_W'(0), CP_W'(0), CP_W'(CP_TOP));
        load_entry(EIDX_W'(15), CP_W'(CP_TOP), CP_W'(CP_TOP));
        load_entry(EIDX_W'(4), CP_W'(CP_TOP), CP_W'(0));
        load_entry(EIDX_W'(5), CP_W'(1), CP_W'(0));
        // one full-range entry: the word's low half picks the code point directly,
        // walking every utf-8 length boundary
        write_ranges_in_use(RIU_W'(1));
        gen_char(64'h0);
        gen_char(64'h7F);
        gen_char(64'h80);
        gen_char(64'h7FF);
        gen_char(64'h800);
        gen_char(64'hFFFF);
        gen_char(64'h10000);
        gen_char(64'h1FFFFF);
        gen_char('1);
        // four entries, one per byte length; words chosen to land in each in turn
        load_entry(EIDX_W'(0), CP_W'(0), CP_W'(0));
        load_entry(EIDX_W'(1), CP_W'('h80), CP_W'('h7FF));
        load_entry(EIDX_W'(2), CP_W'('h800), CP_W'('hFFFF));
        load_entry(EIDX_W'(3), CP_W'('h10000), CP_W'(CP_TOP));
        write_ranges_in_use(RIU_W'(4));
        gen_char(64'd0);
        gen_char(64'd1);
        gen_char(64'd1921);
        gen_char(64'd65409);
        gen_char('1);

        // ---- random part ----
        // fill the whole table first so any count reads only written entries
        for (e = 0; e < MAX_RANGES; e++) begin
            random_range(first, lastcp);
            load_entry(EIDX_W'(e), first, lastcp);
        end

        for (seg = 0; seg < SEGMENTS; seg++) begin
            // idling phase: none, sender gaps, receiver stalls, then both
            case (seg / 3)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 63; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 63; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            // ranges in use: full table, counts past the table, single entry, empty, random partial counts
            case (seg)
                0, 4, 9: active = RIU_W'(MAX_RANGES);
                1, 11:   active = RIU_W'(31);
                2, 7:    active = RIU_W'(1);
                5:       active = RIU_W'(0);
                6:       active = RIU_W'($urandom_range(30, 17));
                3, 8:    active = RIU_W'($urandom_range(15, 2));
                default: active = RIU_W'($urandom_range(MAX_RANGES, 1));
            endcase
            write_ranges_in_use(active);

            for (item = 0; item < SEGMENT_ITEMS; item++) begin
                // now and then the sender holds off until the block has drained
                if ($urandom_range(49) == 0)
                    wait_all_results();
                pick = $urandom_range(99);
                if (pick < 70) begin
                    gen_char(random_word());
                end else if (pick < 90) begin
                    random_range(first, lastcp);
                    load_entry(EIDX_W'($urandom), first, lastcp);
                end else if (pick < 96) begin
                    // inverted range
                    first  = CP_W'($urandom_range(CP_TOP, 1));
                    lastcp = CP_W'($urandom_range(int'(first) - 1, 0));
                    load_entry(EIDX_W'($urandom), first, lastcp);
                end else begin
                    // single code point range
                    first = CP_W'($urandom);
                    load_entry(EIDX_W'($urandom), first, first);
                end
            end
        end

        // drain and give the verdict
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("tb_weighted_range_char_picker: clean");
        else
            $display("tb_weighted_range_char_picker: errors");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/wrcp_pkg.sv
hdl/wrcp_table_ram.sv
hdl/wrcp_mod_unit.sv
hdl/weighted_range_char_picker.sv
hdl/wrcp_checker.sv
test/wrcp_char_checker.sv
test/tb_weighted_range_char_picker.sv
